### design/command_packet_deframer_assert.svh
// Assertion macros for the deframer top-level design file.
`ifndef COMMAND_PACKET_DEFRAMER_ASSERT_SVH
`define COMMAND_PACKET_DEFRAMER_ASSERT_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define CPD_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("deframer check failed");

// Next-cycle implication, checked at every rising edge outside reset.
`define CPD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("deframer check failed");

`endif

### design/cpd_pkg.sv
// Shared constants for the command packet deframer.
package cpd_pkg;

  localparam int BYTE_W       = 8;
  localparam int CMD_W        = 7;
  localparam int HEADER_BYTES = 5;
  localparam int COMMAND_COUNT = 12;
  localparam int MAX_FRAME_BYTES_DEF = 64;
  localparam int CFG_IDX_W    = 2;
  localparam int ACK_IDX_W    = $clog2(HEADER_BYTES);

  localparam logic [CFG_IDX_W-1:0] REG_FIRST_START  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_SECOND_START = CFG_IDX_W'(1);

  localparam logic [BYTE_W-1:0] FIRST_START_RESET  = 8'h41;
  localparam logic [BYTE_W-1:0] SECOND_START_RESET = 8'h42;

endpackage

### design/cpd_ifs.sv
// Valid/ready channel interfaces for the received bytes, acknowledge bytes and configuration.
interface cpd_rx_if;
  import cpd_pkg::*;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] rx_byte;
  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface cpd_ack_if;
  import cpd_pkg::*;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] tx_byte;
  logic              last_byte;
  logic [CMD_W-1:0]  command_index;
  logic              command_valid;
  modport source (output valid, output tx_byte, output last_byte, output command_index,
                  output command_valid, input ready);
  modport sink (input valid, input tx_byte, input last_byte, input command_index,
                input command_valid, output ready);
endinterface

interface cpd_cfg_if;
  import cpd_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [BYTE_W-1:0]    data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

### design/command_packet_deframer.sv
// Top level of the command packet deframer: frame hunt, header capture and acknowledge output.
//
// Channel   Direction  Word
// in_ch     sink       rx_byte, one received byte
// out_ch    source     tx_byte, last_byte, command_index, command_valid
// cfg_ch    sink       index, data; writes a start byte register
//
// Each received byte is decoded in the cycle it is accepted, so one byte per cycle is taken while in_ch is ready.
// A completed frame loads the acknowledge register, which sends five words, one per cycle while out_ch is ready.
// While an acknowledge still waits, in_ch stalls only when the next byte could end a frame.
// Reset is synchronous; it restarts the hunt, empties the acknowledge register and reloads the start bytes.
`include "command_packet_deframer_assert.svh"

module command_packet_deframer #(
  parameter int MAX_FRAME_BYTES = cpd_pkg::MAX_FRAME_BYTES_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  cpd_rx_if.sink     in_ch,
  cpd_ack_if.source  out_ch,
  cpd_cfg_if.sink    cfg_ch
);
  import cpd_pkg::*;

  localparam int CNT_W = $clog2(MAX_FRAME_BYTES + 1);

  localparam logic [CNT_W-1:0] POS_TYPE = CNT_W'(2);
  localparam logic [CNT_W-1:0] POS_SEQ  = CNT_W'(3);
  localparam logic [CNT_W-1:0] POS_LEN  = CNT_W'(4);

  localparam logic [ACK_IDX_W-1:0] ACK_START1 = ACK_IDX_W'(0);
  localparam logic [ACK_IDX_W-1:0] ACK_START2 = ACK_IDX_W'(1);
  localparam logic [ACK_IDX_W-1:0] ACK_TYPE   = ACK_IDX_W'(2);
  localparam logic [ACK_IDX_W-1:0] ACK_SEQ    = ACK_IDX_W'(3);
  localparam logic [ACK_IDX_W-1:0] ACK_LAST   = ACK_IDX_W'(HEADER_BYTES - 1);

  typedef enum logic [3:0] {
    PH_START1 = 4'b0001,
    PH_START2 = 4'b0010,
    PH_HEADER = 4'b0100,
    PH_DATA   = 4'b1000
  } phase_t;

  phase_t             phase_r, phase_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt, cnt_inc;
  logic [BYTE_W-1:0]  start1_r, start2_r;
  logic [BYTE_W-1:0]  type_r, seq_r, len_r;

  logic                 ack_busy_r, ack_busy_nxt;
  logic [ACK_IDX_W-1:0] ack_idx_r, ack_idx_nxt;
  logic [BYTE_W-1:0]    ack_s1_r, ack_s2_r, ack_type_r, ack_seq_r;

  logic              in_fire, out_fire, ack_free, ack_possible, ack_now;
  logic [BYTE_W-1:0] rx_b;
  logic [CMD_W-1:0]  ack_cmd;

  assign rx_b     = in_ch.rx_byte;
  assign in_fire  = in_ch.valid && in_ch.ready;
  assign out_fire = out_ch.valid && out_ch.ready;
  assign cnt_inc  = cnt_r + 1'b1;

  assign ack_free     = !ack_busy_r || (out_ch.ready && ack_idx_r == ACK_LAST);
  assign ack_possible = (phase_r == PH_HEADER && cnt_r == POS_LEN) || (phase_r == PH_DATA);
  assign in_ch.ready  = ack_free || !ack_possible;

  always_comb begin
    phase_nxt = phase_r;
    cnt_nxt   = cnt_r;
    ack_now   = 1'b0;
    unique case (phase_r)
      PH_START1: begin
        cnt_nxt = '0;
        if (rx_b == start1_r) begin
          phase_nxt = PH_START2;
          cnt_nxt   = CNT_W'(1);
        end
      end
      PH_START2: begin
        if (rx_b == start2_r) begin
          phase_nxt = PH_HEADER;
          cnt_nxt   = POS_TYPE;
        end else begin
          phase_nxt = PH_START1;
        end
      end
      PH_HEADER: begin
        cnt_nxt = cnt_inc;
        if (cnt_r == POS_LEN) begin
          if (rx_b == BYTE_W'(HEADER_BYTES)) begin
            ack_now   = 1'b1;
            phase_nxt = PH_START1;
            cnt_nxt   = '0;
          end else begin
            phase_nxt = PH_DATA;
          end
        end
      end
      PH_DATA: begin
        cnt_nxt = cnt_inc;
        if (BYTE_W'(cnt_inc) == len_r) begin
          ack_now   = 1'b1;
          phase_nxt = PH_START1;
          cnt_nxt   = '0;
        end else if (cnt_inc >= CNT_W'(MAX_FRAME_BYTES)) begin
          phase_nxt = PH_START1;
          cnt_nxt   = '0;
        end
      end
      default: begin
        phase_nxt = PH_START1;
        cnt_nxt   = '0;
      end
    endcase
  end

  always_comb begin
    ack_busy_nxt = ack_busy_r;
    ack_idx_nxt  = ack_idx_r;
    if (in_fire && ack_now) begin
      ack_busy_nxt = 1'b1;
      ack_idx_nxt  = '0;
    end else if (out_fire) begin
      if (ack_idx_r == ACK_LAST) begin
        ack_busy_nxt = 1'b0;
      end else begin
        ack_idx_nxt = ack_idx_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_START1;
      cnt_r      <= '0;
      start1_r   <= FIRST_START_RESET;
      start2_r   <= SECOND_START_RESET;
      ack_busy_r <= 1'b0;
      ack_idx_r  <= '0;
    end else begin
      if (in_fire) begin
        phase_r <= phase_nxt;
        cnt_r   <= cnt_nxt;
      end
      ack_busy_r <= ack_busy_nxt;
      ack_idx_r  <= ack_idx_nxt;
      if (cfg_ch.valid && cfg_ch.ready) begin
        unique case (cfg_ch.index)
          REG_FIRST_START:  start1_r <= cfg_ch.data;
          REG_SECOND_START: start2_r <= cfg_ch.data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && phase_r == PH_HEADER) begin
      if (cnt_r == POS_TYPE) begin
        type_r <= rx_b;
      end
      if (cnt_r == POS_SEQ) begin
        seq_r <= rx_b;
      end
      if (cnt_r == POS_LEN) begin
        len_r <= rx_b;
      end
    end
    if (in_fire && ack_now) begin
      ack_s1_r   <= start1_r;
      ack_s2_r   <= start2_r;
      ack_type_r <= type_r;
      ack_seq_r  <= seq_r;
    end
  end

  assign cfg_ch.ready = 1'b1;

  assign ack_cmd              = ack_type_r[BYTE_W-1:1];
  assign out_ch.valid         = ack_busy_r;
  assign out_ch.last_byte     = (ack_idx_r == ACK_LAST);
  assign out_ch.command_index = (ack_idx_r == ACK_START1) ? ack_cmd : '0;
  assign out_ch.command_valid = (ack_idx_r == ACK_START1) &&
                                (BYTE_W'(ack_cmd) < BYTE_W'(COMMAND_COUNT));

  always_comb begin
    case (ack_idx_r)
      ACK_START1: out_ch.tx_byte = ack_s1_r;
      ACK_START2: out_ch.tx_byte = ack_s2_r;
      ACK_TYPE:   out_ch.tx_byte = ack_type_r | BYTE_W'(1);
      ACK_SEQ:    out_ch.tx_byte = ack_seq_r;
      default:    out_ch.tx_byte = BYTE_W'(HEADER_BYTES);
    endcase
  end

  `CPD_ASSERT_IMP(a_no_ack_overrun, in_fire && !ack_free, !ack_now)
  `CPD_ASSERT_NEXT(a_hunt_after_ack, in_fire && ack_now, phase_r == PH_START1 && cnt_r == '0)
  `CPD_ASSERT_NEXT(a_ack_holds, ack_busy_r && !out_ch.ready, ack_busy_r && $stable(ack_idx_r))
  `CPD_ASSERT_IMP(a_data_count, phase_r == PH_DATA,
    cnt_r >= CNT_W'(HEADER_BYTES) && cnt_r < CNT_W'(MAX_FRAME_BYTES))

endmodule
